// ----- hw/rtl/tmea_pkg.sv -----
`timescale 1ns / 1ps

package tmea_pkg;

    // Field widths fixed by the item format.
    localparam int CH_W       = 4;
    localparam int CMD_W      = 2;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Defaults for the top-level parameters.
    localparam int CHANNELS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Width of the shared serial divider's dividend and quotient.
    localparam int DIV_BITS = 96;

    // Command codes on the input channel.
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LATCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TRUNC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd2;

    // Operation carried through the queue once an item is classified.
    typedef enum logic [1:0] {
        OP_ADD,
        OP_LATCH,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic [31:0]                square;
    } q_item_t;

    // One channel's statistics entry.
    typedef struct packed {
        logic [31:0]        count;
        logic signed [47:0] sum;
        logic [63:0]        sq;
        logic [31:0]        mean;
        logic [31:0]        err;
    } chan_entry_t;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] num;
        logic [31:0]         den;
    } div_cmd_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DIV_BITS-1:0] quo;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MEAN,
        ST_M2,
        ST_VAR,
        ST_ROOT,
        ST_OUT
    } state_t;

endpackage

// ----- hw/rtl/tmea_item_if.sv -----
`timescale 1ns / 1ps

interface tmea_item_if;
    logic                                 valid;
    logic                                 ready;
    logic [tmea_pkg::CMD_W-1:0]           cmd;
    logic [tmea_pkg::CH_W-1:0]            channel;
    logic signed [tmea_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, cmd, channel, sample, input ready);
    modport sink (input valid, cmd, channel, sample, output ready);
endinterface

// ----- hw/rtl/tmea_result_if.sv -----
`timescale 1ns / 1ps

interface tmea_result_if;
    logic                       valid;
    logic                       ready;
    logic [tmea_pkg::CH_W-1:0]  out_channel;
    logic signed [31:0]         mean_value;
    logic [31:0]                mean_error;
    logic [31:0]                sample_count;

    modport source (output valid, out_channel, mean_value, mean_error, sample_count,
                    input ready);
    modport sink (input valid, out_channel, mean_value, mean_error, sample_count,
                  output ready);
endinterface

// ----- hw/rtl/tmea_cfg_if.sv -----
`timescale 1ns / 1ps

interface tmea_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tmea_pkg::CFG_IDX_W-1:0]     index;
    logic [tmea_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/truncated_mean_error_accumulator_top.sv -----
`timescale 1ns / 1ps

// Add and clear items hold the back end for a table read, then a write; a latch of an empty
// channel, for the read and the output. Other latches make two or three passes through the
// shared 96-bit serial divider and, unless the variance is negative or overflows, a 32-step
// square root. A 4-entry queue (QUEUE_DEPTH) ahead of the back end takes items one per cycle
// while it is not full. Reset (rst_n, asynchronous, active low) clears the control registers
// and then sweeps the statistics table, one channel per cycle, while no item is taken.
module truncated_mean_error_accumulator_top #(
    parameter int CHANNELS    = tmea_pkg::CHANNELS_DEF,
    parameter int QUEUE_DEPTH = tmea_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tmea_item_if.sink  items,
    tmea_cfg_if.sink   cfg,
    tmea_result_if.source results
);

    logic                push;
    logic                q_full;
    logic                q_valid;
    logic                pop;
    logic                clearing;
    tmea_pkg::q_item_t   push_item;
    tmea_pkg::q_item_t   q_item;
    tmea_pkg::div_cmd_t  div_cmd;
    tmea_pkg::div_rsp_t  div_rsp;

    tmea_front #(.CHANNELS(CHANNELS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cfg       (cfg),
        .q_full    (q_full),
        .clearing  (clearing),
        .push      (push),
        .push_item (push_item)
    );

    tmea_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    tmea_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    tmea_back #(.CHANNELS(CHANNELS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .clearing (clearing),
        .div_cmd  (div_cmd),
        .div_rsp  (div_rsp),
        .results  (results)
    );

endmodule

// ----- hw/rtl/tmea_front.sv -----
`timescale 1ns / 1ps

module tmea_front #(
    parameter int CHANNELS = tmea_pkg::CHANNELS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    tmea_item_if.sink          items,
    tmea_cfg_if.sink           cfg,
    input  logic               q_full,
    input  logic               clearing,
    output logic               push,
    output tmea_pkg::q_item_t  push_item
);

    logic                                 trunc_reg;
    logic signed [tmea_pkg::SAMPLE_W-1:0] lower_reg;
    logic signed [tmea_pkg::SAMPLE_W-1:0] upper_reg;
    logic                                 accept;
    logic                                 in_range;
    logic                                 in_bounds;
    logic signed [31:0]                   square;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trunc_reg <= 1'b0;
            lower_reg <= 16'sh8000;
            upper_reg <= 16'sh7fff;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == tmea_pkg::REG_TRUNC)
            begin
                trunc_reg <= cfg.data[0];
            end
            else if (cfg.index == tmea_pkg::REG_LOWER)
            begin
                lower_reg <= cfg.data;
            end
            else if (cfg.index == tmea_pkg::REG_UPPER)
            begin
                upper_reg <= cfg.data;
            end
        end
    end

    // Classify the item: drop those that cannot change any state.
    assign items.ready = !q_full && !clearing;
    assign accept      = items.valid && items.ready;
    assign in_range    = 32'(items.channel) < CHANNELS;
    assign in_bounds   = !trunc_reg || (items.sample >= lower_reg && items.sample <= upper_reg);
    assign square      = items.sample * items.sample;

    always_comb
    begin
        push_item.channel = items.channel;
        push_item.sample  = items.sample;
        push_item.square  = 32'(square);
        push_item.op      = tmea_pkg::OP_ADD;
        push              = 1'b0;
        if (items.cmd == tmea_pkg::CMD_ADD)
        begin
            push_item.op = tmea_pkg::OP_ADD;
            push         = accept && in_range && in_bounds;
        end
        else if (items.cmd == tmea_pkg::CMD_LATCH)
        begin
            push_item.op = tmea_pkg::OP_LATCH;
            push         = accept && in_range;
        end
        else if (items.cmd == tmea_pkg::CMD_CLEAR)
        begin
            push_item.op = tmea_pkg::OP_CLEAR;
            push         = accept && in_range;
        end
    end

endmodule

// ----- hw/rtl/tmea_queue.sv -----
`timescale 1ns / 1ps

module tmea_queue #(
    parameter int DEPTH = tmea_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tmea_pkg::q_item_t  push_item,
    output logic               full,
    input  logic               pop,
    output logic               q_valid,
    output tmea_pkg::q_item_t  q_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    tmea_pkg::q_item_t  slot_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [PW:0]        count_reg;

    assign full    = count_reg == (PW+1)'(DEPTH);
    assign q_valid = count_reg != '0;
    assign q_item  = slot_reg[rd_ptr_reg];

    // Pointers wrap at the depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
        else $error("queue read while empty");

endmodule

// ----- hw/rtl/tmea_div.sv -----
`timescale 1ns / 1ps

module tmea_div (
    input  logic                clk,
    input  logic                rst_n,
    input  tmea_pkg::div_cmd_t  cmd,
    output tmea_pkg::div_rsp_t  rsp
);

    localparam int NB = tmea_pkg::DIV_BITS;
    localparam int CW = $clog2(NB);

    logic            busy_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [NB-1:0]   num_reg;
    logic [NB-1:0]   quo_reg;
    logic [31:0]     rem_reg;
    logic [31:0]     den_reg;
    logic [32:0]     trial;
    logic            fits;

    // Restoring division, one quotient bit per cycle, dividend MSB first.
    assign trial = {rem_reg, num_reg[NB-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NB-1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start && !busy_reg)
        begin
            num_reg <= cmd.num;
            den_reg <= cmd.den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NB-2:0], 1'b0};
            quo_reg <= {quo_reg[NB-2:0], fits};
            rem_reg <= fits ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ----- hw/rtl/tmea_back.sv -----
`timescale 1ns / 1ps

module tmea_back #(
    parameter int CHANNELS = tmea_pkg::CHANNELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  tmea_pkg::q_item_t   q_item,
    output logic                pop,
    output logic                clearing,
    output tmea_pkg::div_cmd_t  div_cmd,
    input  tmea_pkg::div_rsp_t  div_rsp,
    tmea_result_if.source       results
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    tmea_pkg::state_t       state_reg;
    tmea_pkg::state_t       state_next;
    tmea_pkg::chan_entry_t  mem [CHANNELS];
    tmea_pkg::chan_entry_t  entry_reg;
    tmea_pkg::chan_entry_t  wr_data;
    tmea_pkg::q_item_t      item_reg;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          item_addr;
    logic [AW-1:0]          rd_addr;
    logic [31:0]            rd_ch32;
    logic [31:0]            item_ch32;
    logic [AW-1:0]          clr_idx_reg;
    logic [31:0]            mean_reg;
    logic [31:0]            err_reg;
    logic [31:0]            qm_reg;
    logic [63:0]            ms_reg;
    logic [63:0]            v_reg;
    logic [35:0]            rem_reg;
    logic [31:0]            res_reg;
    logic [4:0]             iter_reg;
    logic [47:0]            mag;
    logic [96:0]            diff;
    logic [35:0]            rem_sh;
    logic [35:0]            root_t;
    logic                   root_fits;
    logic [31:0]            res_next;
    logic                   out_free;
    logic                   res_valid_reg;
    logic [tmea_pkg::CH_W-1:0] res_ch_reg;
    logic [31:0]            res_mean_reg;
    logic [31:0]            res_err_reg;
    logic [31:0]            res_cnt_reg;

    assign rd_ch32   = 32'(q_item.channel);
    assign rd_addr   = rd_ch32[AW-1:0];
    assign item_ch32 = 32'(item_reg.channel);
    assign item_addr = item_ch32[AW-1:0];
    assign out_free  = !res_valid_reg || results.ready;
    assign clearing  = state_reg == tmea_pkg::ST_CLEAR;
    assign pop       = state_reg == tmea_pkg::ST_IDLE && q_valid;

    // Arithmetic helpers for the latch sequence.
    assign mag       = entry_reg.sum[47] ? 48'(-entry_reg.sum) : 48'(entry_reg.sum);
    assign diff      = {1'b0, div_rsp.quo} - {33'b0, ms_reg};
    assign rem_sh    = {rem_reg[33:0], v_reg[63:62]};
    assign root_t    = {2'b0, res_reg, 2'b01};
    assign root_fits = rem_sh >= root_t;
    assign res_next  = {res_reg[30:0], root_fits};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tmea_pkg::ST_CLEAR:
            begin
                if (clr_idx_reg == AW'(CHANNELS-1))
                begin
                    state_next = tmea_pkg::ST_IDLE;
                end
            end
            tmea_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = tmea_pkg::ST_READ;
                end
            end
            tmea_pkg::ST_READ:
            begin
                if (item_reg.op != tmea_pkg::OP_LATCH)
                begin
                    state_next = tmea_pkg::ST_IDLE;
                end
                else if (entry_reg.count == '0)
                begin
                    state_next = tmea_pkg::ST_OUT;
                end
                else
                begin
                    state_next = tmea_pkg::ST_MEAN;
                end
            end
            tmea_pkg::ST_MEAN:
            begin
                if (div_rsp.done)
                begin
                    state_next = tmea_pkg::ST_M2;
                end
            end
            tmea_pkg::ST_M2:
            begin
                if (div_rsp.done)
                begin
                    state_next = diff[96] ? tmea_pkg::ST_OUT : tmea_pkg::ST_VAR;
                end
            end
            tmea_pkg::ST_VAR:
            begin
                if (div_rsp.done)
                begin
                    state_next = (div_rsp.quo[95:64] != '0) ? tmea_pkg::ST_OUT
                                                            : tmea_pkg::ST_ROOT;
                end
            end
            tmea_pkg::ST_ROOT:
            begin
                if (iter_reg == 5'd31)
                begin
                    state_next = tmea_pkg::ST_OUT;
                end
            end
            tmea_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = tmea_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tmea_pkg::ST_IDLE;
            end
        endcase
    end

    // Divider requests and table writes.
    always_comb
    begin
        div_cmd.start = 1'b0;
        div_cmd.num   = {32'b0, mag, 16'b0};
        div_cmd.den   = entry_reg.count;
        wr_en         = 1'b0;
        wr_addr       = item_addr;
        wr_data       = entry_reg;
        unique case (state_reg)
            tmea_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_idx_reg;
                wr_data = '0;
            end
            tmea_pkg::ST_READ:
            begin
                if (item_reg.op == tmea_pkg::OP_ADD)
                begin
                    wr_en         = entry_reg.count != '1;
                    wr_data.count = entry_reg.count + 1'b1;
                    wr_data.sum   = entry_reg.sum + 48'(item_reg.sample);
                    wr_data.sq    = entry_reg.sq + 64'(item_reg.square);
                end
                else if (item_reg.op == tmea_pkg::OP_CLEAR)
                begin
                    wr_en   = 1'b1;
                    wr_data = '0;
                end
                else if (entry_reg.count != '0)
                begin
                    div_cmd.start = 1'b1;
                end
            end
            tmea_pkg::ST_MEAN:
            begin
                div_cmd.num   = {entry_reg.sq, 32'b0};
                div_cmd.start = div_rsp.done;
            end
            tmea_pkg::ST_M2:
            begin
                div_cmd.num   = diff[95:0];
                div_cmd.start = div_rsp.done && !diff[96];
            end
            tmea_pkg::ST_OUT:
            begin
                wr_en        = out_free;
                wr_data.mean = mean_reg;
                wr_data.err  = err_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tmea_pkg::ST_CLEAR;
            clr_idx_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tmea_pkg::ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (state_reg == tmea_pkg::ST_OUT && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Statistics table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (pop)
        begin
            entry_reg <= mem[rd_addr];
            item_reg  <= q_item;
        end
    end

    // Latch datapath: mean, variance and the digit-by-digit square root.
    always_ff @(posedge clk)
    begin
        ms_reg <= qm_reg * qm_reg;
        unique case (state_reg)
            tmea_pkg::ST_READ:
            begin
                mean_reg <= entry_reg.mean;
                err_reg  <= entry_reg.err;
            end
            tmea_pkg::ST_MEAN:
            begin
                if (div_rsp.done)
                begin
                    qm_reg   <= div_rsp.quo[31:0];
                    mean_reg <= entry_reg.sum[47] ? -div_rsp.quo[31:0] : div_rsp.quo[31:0];
                end
            end
            tmea_pkg::ST_M2:
            begin
                if (div_rsp.done)
                begin
                    err_reg <= '0;
                end
            end
            tmea_pkg::ST_VAR:
            begin
                if (div_rsp.done)
                begin
                    err_reg  <= '1;
                    v_reg    <= div_rsp.quo[63:0];
                    rem_reg  <= '0;
                    res_reg  <= '0;
                    iter_reg <= '0;
                end
            end
            tmea_pkg::ST_ROOT:
            begin
                rem_reg  <= root_fits ? rem_sh - root_t : rem_sh;
                res_reg  <= res_next;
                v_reg    <= {v_reg[61:0], 2'b00};
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == 5'd31)
                begin
                    err_reg <= res_next;
                end
            end
            default:
            begin
                iter_reg <= iter_reg;
            end
        endcase
    end

    // Result register parts the block from the result channel.
    always_ff @(posedge clk)
    begin
        if (state_reg == tmea_pkg::ST_OUT && out_free)
        begin
            res_ch_reg   <= item_reg.channel;
            res_mean_reg <= mean_reg;
            res_err_reg  <= err_reg;
            res_cnt_reg  <= entry_reg.count;
        end
    end

    assign results.valid        = res_valid_reg;
    assign results.out_channel  = res_ch_reg;
    assign results.mean_value   = res_mean_reg;
    assign results.mean_error   = res_err_reg;
    assign results.sample_count = res_cnt_reg;

    a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == tmea_pkg::ST_READ)
        else $error("popped item not read");
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == tmea_pkg::ST_MEAN || state_reg == tmea_pkg::ST_M2
                          || state_reg == tmea_pkg::ST_VAR))
        else $error("divider finished with nobody waiting");
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_cmd.start |-> !div_rsp.busy)
        else $error("divider started while busy");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int NCH = tmea_pkg::CHANNELS_DEF;
    localparam int DRAIN_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_PER_PHASE = 255;

    // Codes outside the defined sets, used to check that they are ignored.
    localparam logic [tmea_pkg::CMD_W-1:0]     CMD_UNKNOWN = 2'd3;
    localparam logic [tmea_pkg::CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

    typedef struct {
        logic [tmea_pkg::CH_W-1:0] ch;
        logic [31:0]               mean;
        logic [31:0]               err;
        logic [31:0]               count;
    } stats_t;

    typedef struct {
        logic [tmea_pkg::CMD_W-1:0]           cmd;
        logic [tmea_pkg::CH_W-1:0]            ch;
        logic signed [tmea_pkg::SAMPLE_W-1:0] sample;
        bit                                   lit;
        logic [31:0]                          mean;
        logic [31:0]                          err;
        logic [31:0]                          count;
    } row_t;

    logic clk;
    logic rst_n;

    tmea_item_if   items_if();
    tmea_cfg_if    cfg_if();
    tmea_result_if res_if();

    truncated_mean_error_accumulator_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .cfg     (cfg_if),
        .results (res_if)
    );

    // Predictor state: configuration and per-channel statistics.
    bit                                   m_trunc;
    logic signed [tmea_pkg::SAMPLE_W-1:0] m_lo;
    logic signed [tmea_pkg::SAMPLE_W-1:0] m_hi;
    logic [31:0]                          m_count [NCH];
    logic signed [47:0]                   m_sum   [NCH];
    logic [63:0]                          m_sq    [NCH];
    logic [31:0]                          m_mean  [NCH];
    logic [31:0]                          m_err   [NCH];

    stats_t pending_stats[$];
    int     errors;
    int     snd_idle;
    int     rcv_idle;
    int     items_sent;
    int     idle_cycles;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [31:0] floor_sqrt(logic [63:0] v);
        logic [31:0] r;
        logic [31:0] t;
        r = '0;
        for (int i = 31; i >= 0; i--)
        begin
            t = r | (32'd1 << i);
            if (64'(t) * 64'(t) <= v)
                r = t;
        end
        return r;
    endfunction

    // Fixed-point mean and standard error of one channel.
    task automatic latch_stats(int c);
        logic [63:0] n;
        logic [47:0] mag;
        logic [63:0] qm;
        logic [63:0] ms;
        logic [95:0] m2;
        logic [95:0] v;
        n = 64'(m_count[c]);
        if (n == 0)
            return;
        mag = (m_sum[c] < 0) ? 48'(-m_sum[c]) : 48'(m_sum[c]);
        qm = ({16'b0, mag} << 16) / n;
        m_mean[c] = (m_sum[c] < 0) ? 32'(64'd0 - qm) : qm[31:0];
        m2 = {m_sq[c], 32'b0} / {32'b0, n};
        ms = qm * qm;
        if (m2 < {32'b0, ms})
            m_err[c] = '0;
        else
        begin
            v = (m2 - {32'b0, ms}) / {32'b0, n};
            m_err[c] = (v[95:64] != 0) ? 32'hFFFF_FFFF : floor_sqrt(v[63:0]);
        end
    endtask

    // Applies one accepted item; sets has_res when a result is due.
    task automatic stats_update(logic [tmea_pkg::CMD_W-1:0] cmd,
                                logic [tmea_pkg::CH_W-1:0] ch,
                                logic signed [tmea_pkg::SAMPLE_W-1:0] x, output bit has_res,
                                output stats_t r);
        logic signed [31:0] p;
        int c;
        c = int'(ch);
        has_res = 1'b0;
        r = '{default: '0};
        if (cmd == tmea_pkg::CMD_ADD)
        begin
            if (m_trunc && (x < m_lo || x > m_hi))
                return;
            if (m_count[c] == 32'hFFFF_FFFF)
                return;
            p = x * x;
            m_count[c] = m_count[c] + 1;
            m_sum[c] = m_sum[c] + x;
            m_sq[c] = m_sq[c] + {32'b0, p};
        end
        else if (cmd == tmea_pkg::CMD_CLEAR)
        begin
            m_count[c] = '0;
            m_sum[c] = '0;
            m_sq[c] = '0;
            m_mean[c] = '0;
            m_err[c] = '0;
        end
        else if (cmd == tmea_pkg::CMD_LATCH)
        begin
            latch_stats(c);
            has_res = 1'b1;
            r = '{ch, m_mean[c], m_err[c], m_count[c]};
        end
    endtask

    // Sends one item, honoring the sender idle rate; valid stays high afterwards.
    task automatic send_item(logic [tmea_pkg::CMD_W-1:0] cmd, logic [tmea_pkg::CH_W-1:0] ch,
                             logic signed [tmea_pkg::SAMPLE_W-1:0] x, bit lit,
                             stats_t lit_res);
        bit     has_res;
        stats_t r;
        if ($urandom_range(0, 99) < snd_idle)
        begin
            items_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < snd_idle);
        end
        items_if.valid   <= 1'b1;
        items_if.cmd     <= cmd;
        items_if.channel <= ch;
        items_if.sample  <= x;
        @(posedge clk);
        while (!items_if.ready)
            @(posedge clk);
        stats_update(cmd, ch, x, has_res, r);
        if (has_res)
            pending_stats.insert(pending_stats.size(), lit ? lit_res : r);
        items_sent++;
    endtask

    // Writes one register; cfg valid stays high after acceptance.
    task automatic cfg_write(logic [tmea_pkg::CFG_IDX_W-1:0] idx,
                             logic [tmea_pkg::CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        if (idx == tmea_pkg::REG_TRUNC)
            m_trunc = data[0];
        else if (idx == tmea_pkg::REG_LOWER)
            m_lo = data;
        else if (idx == tmea_pkg::REG_UPPER)
            m_hi = data;
    endtask

    task automatic wait_quiet();
        items_if.valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: check each accepted result, then drive ready for the next cycle.
    always @(posedge clk)
    begin
        stats_t e;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_stats.size() == 0)
            begin
                $display("unexpected result on channel %0d at %0t", res_if.out_channel,
                         $realtime);
                errors++;
            end
            else
            begin
                e = pending_stats.pop_front();
                if (res_if.out_channel !== e.ch)
                    report("out_channel", 32'(res_if.out_channel), 32'(e.ch));
                if (res_if.mean_value !== e.mean)
                    report("mean_value", res_if.mean_value, e.mean);
                if (res_if.mean_error !== e.err)
                    report("mean_error", res_if.mean_error, e.err);
                if (res_if.sample_count !== e.count)
                    report("sample_count", res_if.sample_count, e.count);
            end
        end
        res_if.ready <= ($urandom_range(0, 99) >= rcv_idle);
    end

    // Watchdog on cycles in which no handshake completes.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((items_if.valid && items_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Random sample, biased toward the extremes and the truncation bounds.
    function automatic logic signed [tmea_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return m_lo;
            3: return m_hi;
            4: return m_lo - 16'sd1;
            5: return m_hi + 16'sd1;
            6, 7: return 16'($signed($urandom_range(0, 600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [tmea_pkg::CMD_W-1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 82)
            return tmea_pkg::CMD_ADD;
        if (r < 93)
            return tmea_pkg::CMD_LATCH;
        if (r < 97)
            return tmea_pkg::CMD_CLEAR;
        return CMD_UNKNOWN;
    endfunction

    // Idling schedule follows the number of items already sent.
    function automatic void set_idling();
        if (items_sent < 520)
        begin
            snd_idle = 25;
            rcv_idle = 86;
        end
        else if (items_sent < 1040)
        begin
            snd_idle = 86;
            rcv_idle = 25;
        end
        else
        begin
            snd_idle = 0;
            rcv_idle = 0;
        end
    endfunction

    // Directed rows; literal expectations only where they are obvious.
    row_t directed[] = '{
        '{tmea_pkg::CMD_LATCH, 4'd0,  16'sd0,    1'b1, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_ADD,   4'd1,  16'sh7FFF, 1'b0, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_ADD,   4'd1,  16'sh8000, 1'b0, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_ADD,   4'd1,  16'sd0,    1'b0, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_LATCH, 4'd1,  16'sd0,    1'b0, 32'h0,         32'h0, 32'd0},
        '{CMD_UNKNOWN,         4'd1,  16'shFFFF, 1'b0, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_LATCH, 4'd1,  16'sd0,    1'b0, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_CLEAR, 4'd1,  16'sd0,    1'b0, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_LATCH, 4'd1,  16'sd0,    1'b1, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_ADD,   4'd15, -16'sd1,   1'b0, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_ADD,   4'd15, -16'sd1,   1'b0, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_LATCH, 4'd15, 16'sd0,    1'b1, 32'hFFFF_0000, 32'h0, 32'd2},
        '{tmea_pkg::CMD_ADD,   4'd2,  16'sh7FFF, 1'b0, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_ADD,   4'd2,  16'sh7FFF, 1'b0, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_LATCH, 4'd2,  16'sd0,    1'b1, 32'h7FFF_0000, 32'h0, 32'd2},
        '{tmea_pkg::CMD_ADD,   4'd3,  16'sd1,    1'b0, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_ADD,   4'd3,  -16'sd1,   1'b0, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_ADD,   4'd3,  16'sd5,    1'b0, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_LATCH, 4'd3,  16'sd0,    1'b0, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_ADD,   4'd4,  16'sh8000, 1'b0, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_LATCH, 4'd4,  16'sd0,    1'b1, 32'h8000_0000, 32'h0, 32'd1},
        '{tmea_pkg::CMD_CLEAR, 4'd15, 16'sd0,    1'b0, 32'h0,         32'h0, 32'd0},
        '{tmea_pkg::CMD_LATCH, 4'd15, 16'sd0,    1'b1, 32'h0,         32'h0, 32'd0}
    };

    // Main sequence: reset, directed rows, then random phases over several settings.
    initial
    begin
        stats_t lit_res;
        logic signed [tmea_pkg::SAMPLE_W-1:0] lo_v;
        logic signed [tmea_pkg::SAMPLE_W-1:0] hi_v;
        bit tr_v;

        errors = 0;
        items_sent = 0;
        snd_idle = 0;
        rcv_idle = 0;
        m_trunc = 1'b0;
        m_lo = 16'sh8000;
        m_hi = 16'sh7FFF;
        for (int c = 0; c < NCH; c++)
        begin
            m_count[c] = '0;
            m_sum[c] = '0;
            m_sq[c] = '0;
            m_mean[c] = '0;
            m_err[c] = '0;
        end
        rst_n <= 1'b0;
        items_if.valid <= 1'b0;
        items_if.cmd <= '0;
        items_if.channel <= '0;
        items_if.sample <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        set_idling();
        foreach (directed[i])
        begin
            lit_res = '{directed[i].ch, directed[i].mean, directed[i].err, directed[i].count};
            send_item(directed[i].cmd, directed[i].ch, directed[i].sample, directed[i].lit,
                      lit_res);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_quiet();
            case (ph)
                0:
                begin
                    tr_v = 1'b0;
                    lo_v = 16'($urandom);
                    hi_v = 16'($urandom);
                end
                1:
                begin
                    tr_v = 1'b1;
                    lo_v = 16'sh8000;
                    hi_v = 16'sh7FFF;
                end
                2:
                begin
                    tr_v = 1'b1;
                    lo_v = 16'(0 - $urandom_range(0, 2000));
                    hi_v = 16'($urandom_range(0, 2000));
                end
                3:
                begin
                    // Crossed bounds reject every sample.
                    tr_v = 1'b1;
                    lo_v = 16'sd100;
                    hi_v = -16'sd100;
                end
                4:
                begin
                    tr_v = 1'b1;
                    lo_v = 16'sh7FFF;
                    hi_v = 16'sh7FFF;
                end
                default:
                begin
                    tr_v = 1'b1;
                    lo_v = 16'sh8000;
                    hi_v = 16'sh8000;
                end
            endcase
            cfg_write(tmea_pkg::REG_TRUNC, {15'b0, tr_v});
            cfg_write(tmea_pkg::REG_LOWER, lo_v);
            cfg_write(tmea_pkg::REG_UPPER, hi_v);
            // An index past the register list must be ignored.
            if (ph == 5)
                cfg_write(REG_UNUSED, 16'($urandom));
            cfg_if.valid <= 1'b0;

            for (int k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                set_idling();
                lit_res = '{default: '0};
                send_item(pick_cmd(), 4'($urandom_range(0, NCH - 1)), pick_sample(), 1'b0,
                          lit_res);
            end
        end

        items_if.valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/tmea_pkg.sv
hw/rtl/tmea_item_if.sv
hw/rtl/tmea_result_if.sv
hw/rtl/tmea_cfg_if.sv
hw/rtl/tmea_front.sv
hw/rtl/tmea_queue.sv
hw/rtl/tmea_div.sv
hw/rtl/tmea_back.sv
hw/rtl/truncated_mean_error_accumulator_top.sv
tb/tb.sv
